FILE: hw/rtl/hckc_pkg.sv
// shared types, constants and divider step for the hsv chroma key compositor
package hckc_pkg;

    localparam int unsigned STAGES = 12;

    localparam logic [12:0] HUE_FULL   = 13'd5760;
    localparam logic [12:0] HUE_HALF   = 13'd2880;
    localparam logic [12:0] HUE_GREEN  = 13'd1920;
    localparam logic [12:0] HUE_BLUE   = 13'd3840;
    localparam logic [9:0]  HUE_SECTOR = 10'd960;
    localparam logic [8:0]  ALPHA_ONE  = 9'd256;
    // reciprocal of five in 16 fraction bits, exact for 12-bit operands
    localparam logic [13:0] FIFTH_RECIP = 14'd13108;

    localparam logic [7:0]  RST_KEY_RED   = 8'd0;
    localparam logic [7:0]  RST_KEY_GREEN = 8'd255;
    localparam logic [7:0]  RST_KEY_BLUE  = 8'd0;
    localparam logic [11:0] RST_HUE_WIN   = 12'd640;
    localparam logic [7:0]  RST_SAT_FLOOR = 8'd77;
    localparam logic [8:0]  RST_SPILL     = 9'd128;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [2:0] {
        REG_KEY_RED   = 3'd0,
        REG_KEY_GREEN = 3'd1,
        REG_KEY_BLUE  = 3'd2,
        REG_HUE_WIN   = 3'd3,
        REG_SAT_FLOOR = 3'd4,
        REG_SPILL     = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [7:0] fore_red;
        logic [7:0] fore_green;
        logic [7:0] fore_blue;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] mixed_red;
        logic [7:0] mixed_green;
        logic [7:0] mixed_blue;
    } pixel_out_t;

    typedef struct packed {
        logic        ok;
        logic [12:0] hue;
        logic [7:0]  sat;
    } hs_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // one restoring division step: returns {remainder, quotient bit}
    function automatic logic [20:0] div_step(input logic [19:0] rem,
                                             input logic [9:0] dvs,
                                             input logic [3:0] sh);
        logic [19:0] trial;
        trial = {10'd0, dvs} << sh;
        if (rem >= trial) begin
            return {rem - trial, 1'b1};
        end else begin
            return {rem, 1'b0};
        end
    endfunction

endpackage

FILE: hw/rtl/hckc_hs_unit.sv
// four-stage rgb to hue and saturation converter with pipelined restoring dividers
module hckc_hs_unit (
    input  logic          aclk,
    input  logic [3:0]    en,
    input  hckc_pkg::rgb_t pix,
    output hckc_pkg::hs_t hs
);
    import hckc_pkg::*;

    logic [7:0]  mx, mn, dl, x;
    logic [12:0] base;
    logic        neg;

    logic [19:0] rh1_reg, rs1_reg, rh2_reg, rs2_reg;
    logic [7:0]  dl1_reg, mx1_reg, dl2_reg, mx2_reg;
    logic [12:0] base1_reg, base2_reg, base3_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic        ok1_reg, ok2_reg, ok3_reg;
    logic [4:0]  qh2_reg;
    logic [3:0]  qs2_reg;
    logic [9:0]  qh3_reg;
    logic [7:0]  qs3_reg;
    hs_t         hs_reg;

    logic [19:0] rh_a, rs_a, rh_b, rs_b;
    logic [4:0]  qh_a, qh_b;
    logic [3:0]  qs_a, qs_b;
    logic [20:0] st_a, st_b;

    always_comb begin
        mx = pix.red;
        mn = pix.red;
        if (pix.green > mx) mx = pix.green;
        if (pix.blue > mx) mx = pix.blue;
        if (pix.green < mn) mn = pix.green;
        if (pix.blue < mn) mn = pix.blue;
        dl = mx - mn;
        if (pix.red == mx) begin
            neg  = pix.blue > pix.green;
            base = neg ? HUE_FULL : 13'd0;
            x    = neg ? pix.blue - pix.green : pix.green - pix.blue;
        end else if (pix.green == mx) begin
            neg  = pix.red > pix.blue;
            base = HUE_GREEN;
            x    = neg ? pix.red - pix.blue : pix.blue - pix.red;
        end else begin
            neg  = pix.green > pix.red;
            base = HUE_BLUE;
            x    = neg ? pix.green - pix.red : pix.red - pix.green;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rh1_reg   <= 20'(x) * 20'(HUE_SECTOR);
            rs1_reg   <= 20'(dl) * 20'(8'd255);
            dl1_reg   <= dl;
            mx1_reg   <= mx;
            base1_reg <= base;
            neg1_reg  <= neg;
            ok1_reg   <= dl != 8'd0;
        end
    end

    // upper quotient bits
    always_comb begin
        rh_a = rh1_reg;
        rs_a = rs1_reg;
        qh_a = '0;
        qs_a = '0;
        st_a = '0;
        for (int i = 0; i < 5; i++) begin
            st_a = div_step(rh_a, {2'b00, dl1_reg}, 4'(9 - i));
            rh_a = st_a[20:1];
            qh_a[4 - i] = st_a[0];
        end
        for (int i = 0; i < 4; i++) begin
            st_a = div_step(rs_a, {2'b00, mx1_reg}, 4'(7 - i));
            rs_a = st_a[20:1];
            qs_a[3 - i] = st_a[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            rh2_reg   <= rh_a;
            rs2_reg   <= rs_a;
            qh2_reg   <= qh_a;
            qs2_reg   <= qs_a;
            dl2_reg   <= dl1_reg;
            mx2_reg   <= mx1_reg;
            base2_reg <= base1_reg;
            neg2_reg  <= neg1_reg;
            ok2_reg   <= ok1_reg;
        end
    end

    // lower quotient bits
    always_comb begin
        rh_b = rh2_reg;
        rs_b = rs2_reg;
        qh_b = '0;
        qs_b = '0;
        st_b = '0;
        for (int i = 0; i < 5; i++) begin
            st_b = div_step(rh_b, {2'b00, dl2_reg}, 4'(4 - i));
            rh_b = st_b[20:1];
            qh_b[4 - i] = st_b[0];
        end
        for (int i = 0; i < 4; i++) begin
            st_b = div_step(rs_b, {2'b00, mx2_reg}, 4'(3 - i));
            rs_b = st_b[20:1];
            qs_b[3 - i] = st_b[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            qh3_reg   <= {qh2_reg, qh_b};
            qs3_reg   <= {qs2_reg, qs_b};
            base3_reg <= base2_reg;
            neg3_reg  <= neg2_reg;
            ok3_reg   <= ok2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            hs_reg.ok  <= ok3_reg;
            hs_reg.hue <= neg3_reg ? base3_reg - 13'(qh3_reg) : base3_reg + 13'(qh3_reg);
            hs_reg.sat <= qs3_reg;
        end
    end

    assign hs = hs_reg;

endmodule

FILE: hw/rtl/hckc_alpha_unit.sv
// four-stage hue distance, key decision and soft edge alpha divider
module hckc_alpha_unit (
    input  logic          aclk,
    input  logic [3:0]    en,
    input  hckc_pkg::hs_t pix_hs,
    input  hckc_pkg::hs_t key_hs,
    input  logic [11:0]   hue_window,
    input  logic [7:0]    saturation_floor,
    output logic [8:0]    alpha
);
    import hckc_pkg::*;

    logic [25:0] soft_prod;
    logic [9:0]  soft_reg;
    logic [12:0] d;
    logic [11:0] inner;
    logic        keyed, edge_zone;

    logic [19:0] r5_reg, r6_reg;
    logic        full5_reg, div5_reg, full6_reg, div6_reg, full7_reg, div7_reg;
    logic [4:0]  q6_reg;
    logic [8:0]  q7_reg;
    logic [8:0]  alpha_reg;

    logic [19:0] ra, rb;
    logic [4:0]  qa;
    logic [3:0]  qb;
    logic [20:0] st_a, st_b;

    assign soft_prod = 26'(hue_window) * 26'(FIFTH_RECIP);

    always_ff @(posedge aclk) begin
        soft_reg <= soft_prod[25:16];
    end

    always_comb begin
        d = (pix_hs.hue >= key_hs.hue) ? pix_hs.hue - key_hs.hue : key_hs.hue - pix_hs.hue;
        if (d > HUE_HALF) d = HUE_FULL - d;
        inner     = hue_window - 12'(soft_reg);
        keyed     = key_hs.ok && pix_hs.ok && (pix_hs.sat >= saturation_floor)
                    && (d <= 13'(hue_window));
        edge_zone = (soft_reg != 10'd0) && (d > 13'(inner));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            r5_reg    <= {2'b00, 10'(d - 13'(inner)), 8'd0};
            full5_reg <= !keyed;
            div5_reg  <= keyed && edge_zone;
        end
    end

    always_comb begin
        ra = r5_reg;
        qa = '0;
        st_a = '0;
        for (int i = 0; i < 5; i++) begin
            st_a = div_step(ra, soft_reg, 4'(8 - i));
            ra = st_a[20:1];
            qa[4 - i] = st_a[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            r6_reg    <= ra;
            q6_reg    <= qa;
            full6_reg <= full5_reg;
            div6_reg  <= div5_reg;
        end
    end

    always_comb begin
        rb = r6_reg;
        qb = '0;
        st_b = '0;
        for (int i = 0; i < 4; i++) begin
            st_b = div_step(rb, soft_reg, 4'(3 - i));
            rb = st_b[20:1];
            qb[3 - i] = st_b[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            q7_reg    <= {q6_reg, qb};
            full7_reg <= full6_reg;
            div7_reg  <= div6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            alpha_reg <= full7_reg ? ALPHA_ONE : (div7_reg ? q7_reg : 9'd0);
        end
    end

    assign alpha = alpha_reg;

endmodule

FILE: hw/rtl/hckc_mix_unit.sv
// four-stage spill suppression and alpha blend with clamping
module hckc_mix_unit (
    input  logic                aclk,
    input  logic [3:0]          en,
    input  logic [8:0]          alpha,
    input  hckc_pkg::pixel_in_t pix,
    input  hckc_pkg::rgb_t      key,
    input  logic [8:0]          spill_strength,
    output hckc_pkg::pixel_out_t mixed
);
    import hckc_pkg::*;

    logic       do_spill, green_key, blue_key;
    logic [7:0] ch, target;

    pixel_in_t  p9_reg, p10_reg;
    logic [8:0] a9_reg, a10_reg;
    logic       sg9_reg, sb9_reg, sg10_reg, sb10_reg;
    logic signed [8:0]  diff9_reg;
    logic signed [18:0] prod10_reg;
    logic signed [20:0] sum_r_reg, sum_g_reg, sum_b_reg;
    pixel_out_t out_reg;

    logic signed [18:0] prod;
    logic signed [10:0] step, fr, fg, fb;
    logic [8:0]         inv;

    always_comb begin
        green_key = (key.green > key.red) && (key.green > key.blue);
        blue_key  = (key.blue > key.red) && (key.blue > key.green);
        do_spill  = (spill_strength != 9'd0) && (alpha != 9'd0) && (alpha != ALPHA_ONE);
        if (green_key) begin
            ch     = pix.fore_green;
            target = (pix.fore_red > pix.fore_blue) ? pix.fore_red : pix.fore_blue;
        end else begin
            ch     = pix.fore_blue;
            target = (pix.fore_red > pix.fore_green) ? pix.fore_red : pix.fore_green;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p9_reg    <= pix;
            a9_reg    <= alpha;
            sg9_reg   <= do_spill && green_key;
            sb9_reg   <= do_spill && !green_key && blue_key;
            diff9_reg <= $signed({1'b0, target}) - $signed({1'b0, ch});
        end
    end

    assign prod = 19'(signed'({1'b0, spill_strength}) * diff9_reg);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p10_reg    <= p9_reg;
            a10_reg    <= a9_reg;
            sg10_reg   <= sg9_reg;
            sb10_reg   <= sb9_reg;
            prod10_reg <= prod;
        end
    end

    // quotient by 256 rounded toward zero
    always_comb begin
        step = 11'((prod10_reg + (prod10_reg < 0 ? 19'sd255 : 19'sd0)) >>> 8);
        fr   = $signed({3'b000, p10_reg.fore_red});
        fg   = $signed({3'b000, p10_reg.fore_green}) + (sg10_reg ? step : 11'sd0);
        fb   = $signed({3'b000, p10_reg.fore_blue}) + (sb10_reg ? step : 11'sd0);
        inv  = ALPHA_ONE - a10_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            sum_r_reg <= 21'(fr * $signed({1'b0, a10_reg}))
                       + $signed({4'd0, 17'(p10_reg.back_red * inv)});
            sum_g_reg <= 21'(fg * $signed({1'b0, a10_reg}))
                       + $signed({4'd0, 17'(p10_reg.back_green * inv)});
            sum_b_reg <= 21'(fb * $signed({1'b0, a10_reg}))
                       + $signed({4'd0, 17'(p10_reg.back_blue * inv)});
        end
    end

    function automatic logic [7:0] clamp_div(input logic signed [20:0] s);
        logic signed [12:0] v;
        v = 13'((s + (s < 0 ? 21'sd255 : 21'sd0)) >>> 8);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 13'sd255) begin
            return 8'd255;
        end else begin
            return v[7:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            out_reg.mixed_red   <= clamp_div(sum_r_reg);
            out_reg.mixed_green <= clamp_div(sum_g_reg);
            out_reg.mixed_blue  <= clamp_div(sum_b_reg);
        end
    end

    assign mixed = out_reg;

endmodule

FILE: hw/rtl/hsv_chroma_key_compositor_top.sv
// top level of the hsv hue distance chroma key compositor
//
// s_ channel: one transaction carries a foreground and a background rgb pixel.
// m_ channel: one transaction carries the composited rgb pixel, in input order.
// cfg port: write cfg_we with cfg_index and cfg_data; takes effect at once.
// writes are meant only for when no pixel is in flight; the block itself does
// not enforce this, the user must keep to it.
// throughput: one pixel pair per cycle when the output does not stall;
// twelve register stages, each stage holding its item only while the stage
// after it is full and held.
// the key colour runs through its own free-running hue/saturation unit fed
// from the register write, so it lines up with the first pixel after a write.
// reset clears all valid bits and loads the register defaults; payload
// registers are not reset.
// when m_ready is low the output holds, and the stages behind it keep
// filling their empty slots; s_ready drops only once every stage is full.
module hsv_chroma_key_compositor_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  hckc_pkg::pixel_in_t                   s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output hckc_pkg::pixel_out_t                  m_payload,
    input  logic                                  cfg_we,
    input  logic [hckc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hckc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import hckc_pkg::*;

    logic [7:0]  key_red_reg, key_green_reg, key_blue_reg;
    logic [7:0]  key_red_next, key_green_next, key_blue_next;
    logic [11:0] hue_win_reg, hue_win_next;
    logic [7:0]  sat_floor_reg, sat_floor_next;
    logic [8:0]  spill_reg, spill_next;

    logic [STAGES:1] v_reg, v_next, en;
    pixel_in_t       pay_reg [1:8];

    rgb_t key_rgb, key_rgb_reg, fore_rgb;
    hs_t  key_hs, pix_hs;
    logic [8:0] alpha;

    always_comb begin
        key_red_next   = key_red_reg;
        key_green_next = key_green_reg;
        key_blue_next  = key_blue_reg;
        hue_win_next   = hue_win_reg;
        sat_floor_next = sat_floor_reg;
        spill_next     = spill_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_RED:   key_red_next   = cfg_data[7:0];
                REG_KEY_GREEN: key_green_next = cfg_data[7:0];
                REG_KEY_BLUE:  key_blue_next  = cfg_data[7:0];
                REG_HUE_WIN:   hue_win_next   = cfg_data[11:0];
                REG_SAT_FLOOR: sat_floor_next = cfg_data[7:0];
                REG_SPILL:     spill_next     = cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_red_reg   <= RST_KEY_RED;
            key_green_reg <= RST_KEY_GREEN;
            key_blue_reg  <= RST_KEY_BLUE;
            hue_win_reg   <= RST_HUE_WIN;
            sat_floor_reg <= RST_SAT_FLOOR;
            spill_reg     <= RST_SPILL;
        end else begin
            key_red_reg   <= key_red_next;
            key_green_reg <= key_green_next;
            key_blue_reg  <= key_blue_next;
            hue_win_reg   <= hue_win_next;
            sat_floor_reg <= sat_floor_next;
            spill_reg     <= spill_next;
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb begin
        en[STAGES] = !v_reg[STAGES] || m_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k + 1];
        end
        v_next[1] = en[1] ? s_valid : v_reg[1];
        for (int k = 2; k <= STAGES; k++) begin
            v_next[k] = en[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) pay_reg[1] <= s_payload;
        for (int k = 2; k <= 8; k++) begin
            if (en[k]) pay_reg[k] <= pay_reg[k - 1];
        end
    end

    assign s_ready = en[1];
    assign m_valid = v_reg[STAGES];

    assign key_rgb  = '{red: key_red_next, green: key_green_next, blue: key_blue_next};
    assign key_rgb_reg = '{red: key_red_reg, green: key_green_reg, blue: key_blue_reg};
    assign fore_rgb = '{red: s_payload.fore_red, green: s_payload.fore_green,
                        blue: s_payload.fore_blue};

    hckc_hs_unit u_key_hs (
        .aclk (aclk),
        .en   (4'b1111),
        .pix  (key_rgb),
        .hs   (key_hs)
    );

    hckc_hs_unit u_pix_hs (
        .aclk (aclk),
        .en   (en[4:1]),
        .pix  (fore_rgb),
        .hs   (pix_hs)
    );

    hckc_alpha_unit u_alpha (
        .aclk             (aclk),
        .en               (en[8:5]),
        .pix_hs           (pix_hs),
        .key_hs           (key_hs),
        .hue_window       (hue_win_reg),
        .saturation_floor (sat_floor_reg),
        .alpha            (alpha)
    );

    hckc_mix_unit u_mix (
        .aclk           (aclk),
        .en             (en[12:9]),
        .alpha          (alpha),
        .pix            (pay_reg[8]),
        .key            (key_rgb_reg),
        .spill_strength (spill_reg),
        .mixed          (m_payload)
    );

    a_sink_ready_frees_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output side is ready");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[8] |-> alpha <= ALPHA_ONE)
        else $error("key alpha out of range");

endmodule
